>>> rtl/rsel_pkg.sv
// Shared types, codes and constants for the row shared/exclusive lock slot.
// No dependencies; used by rsel_ctrl, rsel_dp and the top level.
package rsel_pkg;

  localparam int MAX_TX_DEF   = 16;
  localparam int MAX_OIDS_DEF = 4;
  localparam int MAX_RESULTS  = 64;
  localparam int RES_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [2:0] KIND_GRANT    = 3'd0;
  localparam logic [2:0] KIND_QUEUED   = 3'd1;
  localparam logic [2:0] KIND_RELEASED = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd3;
  localparam logic [2:0] KIND_REJECT   = 3'd4;

  localparam logic [1:0] OSEL_ZERO = 2'd0;
  localparam logic [1:0] OSEL_REQ  = 2'd1;
  localparam logic [1:0] OSEL_MEM  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] kind;
    logic [1:0] oid_sel;
    logic       xid_entry;
    logic       gw;
    logic       flush;
    logic       ent_new;
    logic       ent_rec;
    logic       ent_grant;
    logic       ent_clear;
    logic       hold_inc;
    logic       hold_dec;
    logic       hold_wr;
    logic       q_push;
    logic       q_pop;
    logic       q_remove;
    logic       oid_rd;
  } rsel_cmd_t;

  typedef struct packed {
    logic       valid;
    logic       match;
    logic       is_write;
    logic       granted;
    logic       h_rd_zero;
    logic       h_wr_zero;
    logic       q_empty;
    logic       emit_ok;
    logic       out_free;
    logic       pend_valid;
    logic [1:0] mode;
  } rsel_sts_t;

endpackage

>>> rtl/rsel_dp.sv
// Datapath of the lock slot: entry table, oid memory, wait queue, holder
// counts and result registers. Depends on rsel_pkg; driven by rsel_ctrl.
module rsel_dp #(
  parameter int MAX_TX   = rsel_pkg::MAX_TX_DEF,
  parameter int MAX_OIDS = rsel_pkg::MAX_OIDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_mode,
  input  logic [31:0]                       in_xid,
  input  logic [31:0]                       in_oid,
  input  rsel_pkg::rsel_cmd_t               cmd,
  input  logic [$clog2(MAX_TX)-1:0]         cmd_idx,
  input  logic [$clog2(MAX_OIDS+1)-1:0]     cmd_k,
  output rsel_pkg::rsel_sts_t               sts,
  output logic [$clog2(MAX_TX)-1:0]         sts_head,
  output logic [$clog2(MAX_OIDS+1)-1:0]     sts_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_kind,
  output logic [31:0]                       out_xid,
  output logic [31:0]                       out_oid,
  output logic                              out_granted_write,
  output logic                              out_last
);

  localparam int IW    = $clog2(MAX_TX);
  localparam int CW    = $clog2(MAX_OIDS + 1);
  localparam int DEPTH = MAX_TX * MAX_OIDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW    = $clog2(MAX_TX + 1);

  logic [1:0]    req_mode_r;
  logic [31:0]   req_xid_r;
  logic [31:0]   req_oid_r;

  logic          valid_r   [MAX_TX];
  logic          granted_r [MAX_TX];
  logic [CW-1:0] count_r   [MAX_TX];
  logic [31:0]   xid_r     [MAX_TX];
  logic          isw_r     [MAX_TX];

  logic [31:0]   oid_mem [DEPTH];
  logic [31:0]   oid_rd_r;

  logic [IW-1:0] q_r [MAX_TX];
  logic [IW-1:0] q_up [MAX_TX];
  logic          q_shift [MAX_TX];
  logic          q_found;
  logic [HW-1:0] q_len_r;

  logic [HW-1:0] h_rd_r;
  logic [HW-1:0] h_wr_r;

  logic          pend_valid_r;
  logic [2:0]    pend_kind_r;
  logic [31:0]   pend_xid_r;
  logic [31:0]   pend_oid_r;
  logic          pend_gw_r;
  logic          out_valid_r;
  logic [2:0]    out_kind_r;
  logic [31:0]   out_xid_r;
  logic [31:0]   out_oid_r;
  logic          out_gw_r;
  logic          out_last_r;

  logic [CW-1:0] cnt;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          out_free;
  logic          out_load;
  logic [31:0]   new_xid;
  logic [31:0]   new_oid;
  logic          rec_ok;

  assign cnt     = count_r[cmd_idx];
  assign wr_addr = AW'(int'(cmd_idx) * MAX_OIDS + int'(cnt));
  assign rd_addr = AW'(int'(cmd_idx) * MAX_OIDS + int'(cmd_k));
  assign rec_ok  = cnt < CW'(MAX_OIDS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_xid_r  <= in_xid;
      req_oid_r  <= in_oid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TX; i++) begin
        valid_r[i]   <= 1'b0;
        granted_r[i] <= 1'b0;
        count_r[i]   <= '0;
      end
    end else if (cmd.ent_new) begin
      valid_r[cmd_idx]   <= 1'b1;
      granted_r[cmd_idx] <= cmd.ent_grant;
      count_r[cmd_idx]   <= CW'(1);
    end else begin
      if (cmd.ent_rec && rec_ok) count_r[cmd_idx] <= cnt + CW'(1);
      if (cmd.ent_grant) granted_r[cmd_idx] <= 1'b1;
      if (cmd.ent_clear) begin
        valid_r[cmd_idx]   <= 1'b0;
        granted_r[cmd_idx] <= 1'b0;
        count_r[cmd_idx]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ent_new) begin
      xid_r[cmd_idx] <= req_xid_r;
      isw_r[cmd_idx] <= (req_mode_r == rsel_pkg::MODE_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ent_new || (cmd.ent_rec && rec_ok)) oid_mem[wr_addr] <= req_oid_r;
    if (cmd.oid_rd) oid_rd_r <= oid_mem[rd_addr];
  end

  always_comb begin
    q_found = 1'b0;
    for (int k = 0; k < MAX_TX; k++) begin
      q_found    = q_found | ((q_r[k] == cmd_idx) && (HW'(k) < q_len_r));
      q_shift[k] = q_found;
    end
    for (int k = 0; k < MAX_TX - 1; k++) q_up[k] = q_r[k+1];
    q_up[MAX_TX-1] = q_r[MAX_TX-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_push) begin
      q_r[q_len_r[IW-1:0]] <= cmd_idx;
    end else if (cmd.q_pop) begin
      for (int k = 0; k < MAX_TX; k++) q_r[k] <= q_up[k];
    end else if (cmd.q_remove) begin
      for (int k = 0; k < MAX_TX; k++) if (q_shift[k]) q_r[k] <= q_up[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_len_r <= '0;
      h_rd_r  <= '0;
      h_wr_r  <= '0;
    end else begin
      if (cmd.q_push) q_len_r <= q_len_r + HW'(1);
      else if (cmd.q_pop || (cmd.q_remove && q_found)) q_len_r <= q_len_r - HW'(1);
      if (cmd.hold_inc) begin
        if (cmd.hold_wr) h_wr_r <= h_wr_r + HW'(1);
        else             h_rd_r <= h_rd_r + HW'(1);
      end else if (cmd.hold_dec) begin
        if (cmd.hold_wr) begin
          if (h_wr_r != '0) h_wr_r <= h_wr_r - HW'(1);
        end else begin
          if (h_rd_r != '0) h_rd_r <= h_rd_r - HW'(1);
        end
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.emit && pend_valid_r) || cmd.flush;
  assign new_xid  = cmd.xid_entry ? xid_r[cmd_idx] : req_xid_r;

  always_comb begin
    unique case (cmd.oid_sel)
      rsel_pkg::OSEL_REQ: new_oid = req_oid_r;
      rsel_pkg::OSEL_MEM: new_oid = oid_rd_r;
      default:            new_oid = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      if (cmd.emit) pend_valid_r <= 1'b1;
      else if (cmd.flush) pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= pend_kind_r;
      out_xid_r  <= pend_xid_r;
      out_oid_r  <= pend_oid_r;
      out_gw_r   <= pend_gw_r;
      out_last_r <= cmd.flush;
    end
    if (cmd.emit) begin
      pend_kind_r <= cmd.kind;
      pend_xid_r  <= new_xid;
      pend_oid_r  <= new_oid;
      pend_gw_r   <= cmd.gw;
    end
  end

  assign sts.valid      = valid_r[cmd_idx];
  assign sts.match      = valid_r[cmd_idx] && (xid_r[cmd_idx] == req_xid_r);
  assign sts.is_write   = isw_r[cmd_idx];
  assign sts.granted    = granted_r[cmd_idx];
  assign sts.h_rd_zero  = (h_rd_r == '0);
  assign sts.h_wr_zero  = (h_wr_r == '0);
  assign sts.q_empty    = (q_len_r == '0);
  assign sts.emit_ok    = !pend_valid_r || out_free;
  assign sts.out_free   = out_free;
  assign sts.pend_valid = pend_valid_r;
  assign sts.mode       = req_mode_r;
  assign sts_head       = q_r[0];
  assign sts_count      = cnt;

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_xid           = out_xid_r;
  assign out_oid           = out_oid_r;
  assign out_granted_write = out_gw_r;
  assign out_last          = out_last_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!pend_valid_r || out_free))
    else $error("result pushed with no room");
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    h_wr_r <= HW'(1))
    else $error("more than one writer holds the lock");
  a_no_mixed: assert property (@(posedge clk) disable iff (!rst_n)
    !(h_rd_r != '0 && h_wr_r != '0))
    else $error("readers and writer hold together");
  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (pend_valid_r && out_free))
    else $error("flush without pending result");
  a_qlen: assert property (@(posedge clk) disable iff (!rst_n)
    q_len_r <= HW'(MAX_TX))
    else $error("wait queue overflow");

endmodule

>>> rtl/rsel_ctrl.sv
// Controller state machine of the lock slot: table scan, request decision,
// queue scan and result sequencing. Depends on rsel_pkg; drives rsel_dp.
module rsel_ctrl #(
  parameter int MAX_TX   = rsel_pkg::MAX_TX_DEF,
  parameter int MAX_OIDS = rsel_pkg::MAX_OIDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  output rsel_pkg::rsel_cmd_t               cmd,
  output logic [$clog2(MAX_TX)-1:0]         cmd_idx,
  output logic [$clog2(MAX_OIDS+1)-1:0]     cmd_k,
  input  rsel_pkg::rsel_sts_t               sts,
  input  logic [$clog2(MAX_TX)-1:0]         sts_head,
  input  logic [$clog2(MAX_OIDS+1)-1:0]     sts_count
);

  localparam int IW = $clog2(MAX_TX);
  localparam int CW = $clog2(MAX_OIDS + 1);
  localparam int RW = rsel_pkg::RES_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DECIDE  = 3'd2;
  localparam logic [2:0] ST_QSCAN   = 3'd3;
  localparam logic [2:0] ST_OID_RD  = 3'd4;
  localparam logic [2:0] ST_OID_EM  = 3'd5;
  localparam logic [2:0] ST_RELDONE = 3'd6;
  localparam logic [2:0] ST_FINISH  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [IW:0]   i_r, i_nxt;
  logic          hit_r, hit_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] e_r, e_nxt;
  logic [IW-1:0] f_r, f_nxt;
  logic [IW-1:0] g_r, g_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [RW-1:0] n_r, n_nxt;
  logic          readers_r, readers_nxt;
  logic          ret_q_r, ret_q_nxt;
  logic          wr_req;
  logic          can_grant;

  assign in_stall  = (state_r != ST_IDLE);
  assign wr_req    = (sts.mode == rsel_pkg::MODE_WRITE);
  assign can_grant = sts.h_wr_zero && (!wr_req || sts.h_rd_zero);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    hit_nxt     = hit_r;
    free_nxt    = free_r;
    e_nxt       = e_r;
    f_nxt       = f_r;
    g_nxt       = g_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    readers_nxt = readers_r;
    ret_q_nxt   = ret_q_r;
    cmd         = '0;
    cmd_idx     = '0;
    cmd_k       = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode != rsel_pkg::MODE_NONE) begin
            state_nxt = ST_SCAN;
            i_nxt     = '0;
            hit_nxt   = 1'b0;
            free_nxt  = 1'b0;
            n_nxt     = '0;
          end
        end
      end
      ST_SCAN: begin
        cmd_idx = i_r[IW-1:0];
        if (sts.match && !hit_r) begin
          hit_nxt = 1'b1;
          e_nxt   = i_r[IW-1:0];
        end
        if (!sts.valid && !free_r) begin
          free_nxt = 1'b1;
          f_nxt    = i_r[IW-1:0];
        end
        if (i_r == (IW+1)'(MAX_TX - 1)) state_nxt = ST_DECIDE;
        else i_nxt = i_r + (IW+1)'(1);
      end
      ST_DECIDE: begin
        if (sts.mode == rsel_pkg::MODE_RELEASE) begin
          if (!hit_r) begin
            if (sts.emit_ok) begin
              cmd.emit  = 1'b1;
              cmd.kind  = rsel_pkg::KIND_UNKNOWN;
              n_nxt     = n_r + RW'(1);
              state_nxt = ST_FINISH;
            end
          end else begin
            cmd_idx       = e_r;
            cmd.ent_clear = 1'b1;
            if (sts.granted) begin
              cmd.hold_dec = 1'b1;
              cmd.hold_wr  = sts.is_write;
            end else begin
              cmd.q_remove = 1'b1;
            end
            readers_nxt = 1'b0;
            state_nxt   = ST_QSCAN;
          end
        end else if (hit_r) begin
          cmd_idx = e_r;
          if (sts.emit_ok) begin
            cmd.ent_rec = 1'b1;
            cmd.emit    = 1'b1;
            if (sts.granted) begin
              cmd.kind    = rsel_pkg::KIND_GRANT;
              cmd.oid_sel = rsel_pkg::OSEL_REQ;
              cmd.gw      = sts.is_write;
            end else begin
              cmd.kind = rsel_pkg::KIND_QUEUED;
            end
            n_nxt     = n_r + RW'(1);
            state_nxt = ST_FINISH;
          end
        end else if (!free_r) begin
          if (sts.emit_ok) begin
            cmd.emit  = 1'b1;
            cmd.kind  = rsel_pkg::KIND_REJECT;
            n_nxt     = n_r + RW'(1);
            state_nxt = ST_FINISH;
          end
        end else begin
          cmd_idx = f_r;
          if (sts.emit_ok) begin
            cmd.ent_new = 1'b1;
            cmd.emit    = 1'b1;
            if (can_grant) begin
              cmd.ent_grant = 1'b1;
              cmd.hold_inc  = 1'b1;
              cmd.hold_wr   = wr_req;
              cmd.kind      = rsel_pkg::KIND_GRANT;
              cmd.oid_sel   = rsel_pkg::OSEL_REQ;
              cmd.gw        = wr_req;
            end else begin
              cmd.q_push = 1'b1;
              cmd.kind   = rsel_pkg::KIND_QUEUED;
            end
            n_nxt     = n_r + RW'(1);
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_QSCAN: begin
        cmd_idx = sts_head;
        if (sts.q_empty) begin
          state_nxt = ST_RELDONE;
        end else if (!sts.is_write) begin
          if (!sts.h_wr_zero) begin
            state_nxt = ST_RELDONE;
          end else begin
            cmd.q_pop     = 1'b1;
            cmd.ent_grant = 1'b1;
            cmd.hold_inc  = 1'b1;
            g_nxt         = sts_head;
            k_nxt         = '0;
            readers_nxt   = 1'b1;
            ret_q_nxt     = 1'b1;
            state_nxt     = ST_OID_RD;
          end
        end else if (!readers_r && sts.h_rd_zero && sts.h_wr_zero) begin
          cmd.q_pop     = 1'b1;
          cmd.ent_grant = 1'b1;
          cmd.hold_inc  = 1'b1;
          cmd.hold_wr   = 1'b1;
          g_nxt         = sts_head;
          k_nxt         = '0;
          ret_q_nxt     = 1'b0;
          state_nxt     = ST_OID_RD;
        end else begin
          state_nxt = ST_RELDONE;
        end
      end
      ST_OID_RD: begin
        cmd_idx = g_r;
        if (k_r >= sts_count) begin
          state_nxt = ret_q_r ? ST_QSCAN : ST_RELDONE;
        end else begin
          cmd.oid_rd = 1'b1;
          state_nxt  = ST_OID_EM;
        end
      end
      ST_OID_EM: begin
        cmd_idx = g_r;
        if (n_r >= RW'(rsel_pkg::MAX_RESULTS)) begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_OID_RD;
        end else if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.kind      = rsel_pkg::KIND_GRANT;
          cmd.oid_sel   = rsel_pkg::OSEL_MEM;
          cmd.xid_entry = 1'b1;
          cmd.gw        = sts.is_write;
          n_nxt         = n_r + RW'(1);
          k_nxt         = k_r + CW'(1);
          state_nxt     = ST_OID_RD;
        end
      end
      ST_RELDONE: begin
        if (n_r != '0) begin
          state_nxt = ST_FINISH;
        end else if (sts.emit_ok) begin
          cmd.emit  = 1'b1;
          cmd.kind  = rsel_pkg::KIND_RELEASED;
          n_nxt     = n_r + RW'(1);
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      i_r       <= '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      n_r       <= '0;
      readers_r <= 1'b0;
      ret_q_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      hit_r     <= hit_nxt;
      free_r    <= free_nxt;
      n_r       <= n_nxt;
      readers_r <= readers_nxt;
      ret_q_r   <= ret_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
    f_r <= f_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

endmodule

>>> rtl/row_shared_exclusive_lock_slot.sv
// Row lock slot: shared/exclusive lock with a FIFO wait queue for one row.
// Top level; instantiates rsel_ctrl and rsel_dp, uses rsel_pkg.
// One request at a time: the transaction table is searched one entry per
// cycle, then a read or write request is decided and its result flushed.
// A release goes on to scan the wait queue from its head and to a closing
// step. Each granted object id is read from the oid memory, then emitted
// as a result. Stalls on the result side hold the sequence. The result
// channel carries one result per read or write request; a release gives
// one per object id granted, up to MAX_RESULTS, or a single one when it
// grants none, with last marking the final one.
module row_shared_exclusive_lock_slot #(
  parameter int MAX_TX   = rsel_pkg::MAX_TX_DEF,
  parameter int MAX_OIDS = rsel_pkg::MAX_OIDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_xid,
  input  logic [31:0] in_oid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_xid,
  output logic [31:0] out_oid,
  output logic        out_granted_write,
  output logic        out_last
);

  rsel_pkg::rsel_cmd_t             cmd;
  rsel_pkg::rsel_sts_t             sts;
  logic [$clog2(MAX_TX)-1:0]       cmd_idx;
  logic [$clog2(MAX_OIDS+1)-1:0]   cmd_k;
  logic [$clog2(MAX_TX)-1:0]       sts_head;
  logic [$clog2(MAX_OIDS+1)-1:0]   sts_count;

  rsel_ctrl #(.MAX_TX(MAX_TX), .MAX_OIDS(MAX_OIDS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .cmd       (cmd),
    .cmd_idx   (cmd_idx),
    .cmd_k     (cmd_k),
    .sts       (sts),
    .sts_head  (sts_head),
    .sts_count (sts_count)
  );

  rsel_dp #(.MAX_TX(MAX_TX), .MAX_OIDS(MAX_OIDS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_xid            (in_xid),
    .in_oid            (in_oid),
    .cmd               (cmd),
    .cmd_idx           (cmd_idx),
    .cmd_k             (cmd_k),
    .sts               (sts),
    .sts_head          (sts_head),
    .sts_count         (sts_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_xid           (out_xid),
    .out_oid           (out_oid),
    .out_granted_write (out_granted_write),
    .out_last          (out_last)
  );

endmodule
